/* hdl/zoned_track_sector_to_block_macros.svh */
// Assertion helpers for the checker file of this block.
// Every macro samples on clk and is switched off while rst_n is low.
`ifndef ZONED_TRACK_SECTOR_TO_BLOCK_MACROS_SVH
`define ZONED_TRACK_SECTOR_TO_BLOCK_MACROS_SVH

// Same-cycle implication.
`define ZTSB_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication with a fixed delay in cycles.
`define ZTSB_ASSERT_DELAY(label, ante, dly, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error(msg);

`endif

/* hdl/ztsb_pkg.sv */
package ztsb_pkg;

  localparam int ZONE_REGS = 4;
  localparam int BLOCK_W   = 18;
  localparam int OFFSET_W  = 26;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_ZONE_0     = 3'd0;
  localparam cfg_idx_t CFG_ZONE_1     = 3'd1;
  localparam cfg_idx_t CFG_ZONE_2     = 3'd2;
  localparam cfg_idx_t CFG_ZONE_3     = 3'd3;
  localparam cfg_idx_t CFG_LAST_TRACK = 3'd4;

  localparam logic [1:0] MAP_OK         = 2'd0;
  localparam logic [1:0] MAP_BAD_TRACK  = 2'd1;
  localparam logic [1:0] MAP_BAD_SECTOR = 2'd2;

  typedef struct packed {
    logic [7:0] first;
    logic [7:0] last;
    logic [7:0] secs;
  } zone_t;

  localparam zone_t ZONE_0_RESET = 24'd69909;
  localparam zone_t ZONE_1_RESET = 24'd1185811;
  localparam zone_t ZONE_2_RESET = 24'd1646098;
  localparam zone_t ZONE_3_RESET = 24'd2040593;
  localparam logic [7:0] LAST_TRACK_RESET = 8'd35;

  typedef struct packed {
    logic [7:0] track_in;
    logic [7:0] sector_in;
  } in_t;

  typedef struct packed {
    logic [BLOCK_W-1:0]  block_index;
    logic [OFFSET_W-1:0] byte_offset;
    logic [1:0]          map_error;
    logic [7:0]          track_sectors;
    logic                count_error;
  } out_t;

  // Result of the mapping stage, before the byte offset is formed.
  typedef struct packed {
    logic               valid;
    logic [BLOCK_W-1:0] block_index;
    logic [1:0]         map_error;
    logic [7:0]         track_sectors;
    logic               count_error;
  } mid_t;

endpackage

/* hdl/ztsb_cfg.sv */
module ztsb_cfg import ztsb_pkg::*; #(
  parameter int ZONE_COUNT = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  cfg_idx_t                             cfg_index,
  input  logic [23:0]                          cfg_data,
  output zone_t [ZONE_COUNT-1:0]               zones,
  output logic  [ZONE_COUNT-1:0][BLOCK_W-1:0]  zone_base,
  output logic  [7:0]                          last_track
);

  zone_t       zone_r [ZONE_REGS];
  logic [7:0]  last_track_r;
  logic [ZONE_COUNT-1:0][BLOCK_W-1:0] base_r;
  logic [ZONE_COUNT-1:0][BLOCK_W-1:0] base_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      zone_r[0]    <= ZONE_0_RESET;
      zone_r[1]    <= ZONE_1_RESET;
      zone_r[2]    <= ZONE_2_RESET;
      zone_r[3]    <= ZONE_3_RESET;
      last_track_r <= LAST_TRACK_RESET;
    end else if (cfg_valid) begin
      priority if (cfg_index <= CFG_ZONE_3) begin
        zone_r[cfg_index[1:0]] <= cfg_data;
      end else if (cfg_index == CFG_LAST_TRACK) begin
        last_track_r <= cfg_data[7:0];
      end else begin
        // Writes to indexes past the last register are dropped.
      end
    end
  end

  // Zones past the register set read as zero, which ends the table.
  for (genvar z = 0; z < ZONE_COUNT; z++) begin : g_zone
    if (z < ZONE_REGS) begin : g_reg
      assign zones[z] = zone_r[z];
    end else begin : g_zero
      assign zones[z] = '0;
    end
  end

  // Block number at which each zone starts, registered: it follows the
  // zone registers in the next cycle. Items see no lag if the user changes
  // the configuration only while the block is idle; this is not enforced.
  always_comb begin
    logic [8:0]  span;
    logic [16:0] size;
    base_nxt[0] = '0;
    for (int z = 1; z < ZONE_COUNT; z++) begin
      span = 9'(zones[z-1].last) - 9'(zones[z-1].first) + 9'd1;
      size = (zones[z-1].last >= zones[z-1].first) ?
             17'(span) * 17'(zones[z-1].secs) : 17'd0;
      base_nxt[z] = base_nxt[z-1] + BLOCK_W'(size);
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
  end

  assign zone_base  = base_r;
  assign last_track = last_track_r;

endmodule

/* hdl/ztsb_map.sv */
module ztsb_map import ztsb_pkg::*; #(
  parameter int ZONE_COUNT = 4
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 item_vld,
  input  in_t                                  item,
  input  zone_t [ZONE_COUNT-1:0]               zones,
  input  logic  [ZONE_COUNT-1:0][BLOCK_W-1:0]  zone_base,
  input  logic  [7:0]                          last_track,
  output mid_t                                 mid
);

  mid_t mid_nxt;
  mid_t mid_r;

  always_comb begin
    logic               visiting;
    logic               found;
    logic [1:0]         merr;
    logic [7:0]         sel_first;
    logic [7:0]         sel_secs;
    logic [BLOCK_W-1:0] sel_base;
    logic [15:0]        in_zone;
    logic [BLOCK_W-1:0] block;
    logic               cdone;
    logic [7:0]         csecs;
    logic               cerr;

    visiting  = 1'b1;
    found     = 1'b0;
    merr      = MAP_BAD_TRACK;
    sel_first = '0;
    sel_secs  = '0;
    sel_base  = '0;
    // Zones are visited in order; the sector is checked in every visited
    // zone before the track is looked for in it.
    for (int z = 0; z < ZONE_COUNT; z++) begin
      if (visiting && !found) begin
        priority if (zones[z].first == 8'd0) begin
          visiting = 1'b0;
        end else if (item.sector_in >= zones[z].secs) begin
          found = 1'b1;
          merr  = MAP_BAD_SECTOR;
        end else if (item.track_in >= zones[z].first &&
                     item.track_in <= zones[z].last) begin
          found     = 1'b1;
          merr      = MAP_OK;
          sel_first = zones[z].first;
          sel_secs  = zones[z].secs;
          sel_base  = zone_base[z];
        end else begin
          // The track lies outside this zone; keep walking.
        end
      end
    end
    if (item.track_in == 8'd0) begin
      merr = MAP_BAD_TRACK;
    end

    in_zone = 16'(item.track_in - sel_first) * 16'(sel_secs);
    block   = sel_base + BLOCK_W'(in_zone) + BLOCK_W'(item.sector_in);
    if (merr != MAP_OK) begin
      block = '0;
    end

    cdone = 1'b0;
    csecs = '0;
    for (int z = 0; z < ZONE_COUNT; z++) begin
      if (!cdone) begin
        priority if (zones[z].first == 8'd0) begin
          cdone = 1'b1;
        end else if (zones[z].last == 8'd0 || item.track_in <= zones[z].last) begin
          cdone = 1'b1;
          csecs = zones[z].secs;
        end else begin
          // The track lies past this zone; keep walking.
        end
      end
    end
    cerr = (item.track_in == 8'd0) || (item.track_in > last_track);
    if (cerr) begin
      csecs = '0;
    end

    mid_nxt.valid         = item_vld;
    mid_nxt.block_index   = block;
    mid_nxt.map_error     = merr;
    mid_nxt.track_sectors = csecs;
    mid_nxt.count_error   = cerr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= '0;
    end else begin
      mid_r <= mid_nxt;
    end
  end

  assign mid = mid_r;

endmodule

/* hdl/zoned_track_sector_to_block.sv */
// Maps a track and sector of a zoned disk to a linear block number.
// Input channel: an item (track, sector) is taken at a clock edge where
// start is high and busy is low. busy is high only while rst_n is low, so
// one item can be started in every cycle.
// Result channel: out_strobe is high for one cycle with the result beat on
// out_item, once the item has passed the input, mapping and output
// registers; block number, byte offset and error codes share that one beat.
// Throughput is one item per cycle; latency is set by the three register
// stages: input register, zone lookup and multiply, byte offset multiply.
// The receiver cannot stall; every result is shown for exactly one cycle.
// Configuration channel: cfg_valid with cfg_ready (always high) writes
// cfg_data to register cfg_index: zone words 0 to 3, then last_track.
// Other indexes are ignored. Write it only with no item in flight.
// Reset (synchronous, active low) restores the default zone table and
// drops any item in flight; no result beat comes out for it.
module zoned_track_sector_to_block import ztsb_pkg::*; #(
  parameter int ZONE_COUNT  = 4,
  parameter int BLOCK_BYTES = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_t         in_item,
  output logic        out_strobe,
  output out_t        out_item,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  cfg_idx_t    cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int BB_W   = $clog2(BLOCK_BYTES + 1);
  localparam int PROD_W = (BLOCK_W + BB_W > OFFSET_W) ? BLOCK_W + BB_W : OFFSET_W;

  logic                                accept;
  logic                                in_vld_r;
  in_t                                 in_r;
  zone_t [ZONE_COUNT-1:0]              zones;
  logic  [ZONE_COUNT-1:0][BLOCK_W-1:0] zone_base;
  logic  [7:0]                         last_track;
  mid_t                                mid;
  logic [PROD_W-1:0]                   offset_full;
  logic                                out_strobe_r;
  out_t                                out_r;
  out_t                                out_nxt;

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_item;
    end
  end

  ztsb_cfg #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .zones      (zones),
    .zone_base  (zone_base),
    .last_track (last_track)
  );

  ztsb_map #(
    .ZONE_COUNT (ZONE_COUNT)
  ) u_map (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_vld   (in_vld_r),
    .item       (in_r),
    .zones      (zones),
    .zone_base  (zone_base),
    .last_track (last_track),
    .mid        (mid)
  );

  // The block number is already zero on a map error, so the offset is too.
  assign offset_full = PROD_W'(mid.block_index) * PROD_W'(BLOCK_BYTES);

  always_comb begin
    out_nxt.block_index   = mid.block_index;
    out_nxt.byte_offset   = offset_full[OFFSET_W-1:0];
    out_nxt.map_error     = mid.map_error;
    out_nxt.track_sectors = mid.track_sectors;
    out_nxt.count_error   = mid.count_error;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= mid.valid;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

/* hdl/ztsb_chk.sv */
`include "zoned_track_sector_to_block_macros.svh"

module ztsb_chk import ztsb_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_strobe,
  input out_t out_item
);

  // Every started item gives exactly one result beat, and no beat comes without an item.
  `ZTSB_ASSERT_DELAY(a_result_follows, start && !busy, 3, out_strobe, "result beat missing")
  `ZTSB_ASSERT_IMPLY(a_no_stray_beat, out_strobe, $past(start && !busy, 3), "result beat without item")
  `ZTSB_ASSERT_IMPLY(a_map_err_zero, out_strobe && out_item.map_error != MAP_OK, out_item.block_index == '0 && out_item.byte_offset == '0, "nonzero block on map error")
  `ZTSB_ASSERT_IMPLY(a_count_err_zero, out_strobe && out_item.count_error, out_item.track_sectors == 8'd0, "nonzero sector count on count error")

endmodule

bind zoned_track_sector_to_block ztsb_chk u_ztsb_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

/* tb/sv/zoned_track_sector_to_block_tb.sv */
`timescale 1ns / 100ps

module zoned_track_sector_to_block_tb;
  import ztsb_pkg::*;

  localparam int ZONE_COUNT   = 4;
  localparam int BLOCK_BYTES  = 256;
  localparam int PHASES       = 8;
  localparam int PER_PHASE    = 116;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_CYCLES = 6;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        start      = 1'b0;
  logic        busy;
  in_t         in_item    = '0;
  logic        out_strobe;
  out_t        out_item;
  logic        cfg_valid  = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index  = CFG_ZONE_0;
  logic [23:0] cfg_data   = '0;

  // Mirror of the configuration registers as the block should hold them.
  zone_t       zone_reg [ZONE_REGS];
  logic [7:0]  last_trk;

  in_t         query_q [$];
  out_t        expected_maps [$];
  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int          errors       = 0;
  int          idle_pct     = 0;
  int          quiet_cycles = 0;

  always #5 clk = ~clk;

  zoned_track_sector_to_block #(
    .ZONE_COUNT (ZONE_COUNT),
    .BLOCK_BYTES(BLOCK_BYTES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic zone_t zone_at(input int z);
    if (z < ZONE_REGS) return zone_reg[z];
    return '0;
  endfunction

  function automatic out_t map_query(input in_t q);
    out_t        r;
    zone_t       w;
    int unsigned tr;
    int unsigned sc;
    int unsigned lo;
    int unsigned hi;
    int unsigned ns;
    int unsigned acc;
    int unsigned blk;
    logic [63:0] off;
    logic        done;
    r = '0;
    tr = q.track_in;
    sc = q.sector_in;
    acc = 0;
    done = 1'b0;
    r.map_error = MAP_BAD_TRACK;
    if (tr != 0) begin
      for (int z = 0; z < ZONE_COUNT && !done; z++) begin
        w = zone_at(z);
        lo = w.first;
        hi = w.last;
        ns = w.secs;
        if (lo == 0) begin
          done = 1'b1;
        end else if (sc >= ns) begin
          // The sector has to fit every zone walked so far, not only its own.
          r.map_error = MAP_BAD_SECTOR;
          done = 1'b1;
        end else if (tr >= lo && tr <= hi) begin
          blk = acc + (tr - lo) * ns + sc;
          r.block_index = blk[BLOCK_W-1:0];
          r.map_error = MAP_OK;
          done = 1'b1;
        end else if (hi >= lo) begin
          acc += (hi - lo + 1) * ns;
        end
      end
    end
    if (r.map_error == MAP_OK) begin
      off = 64'(r.block_index) * 64'(BLOCK_BYTES);
      r.byte_offset = off[OFFSET_W-1:0];
    end

    if (tr == 0 || tr > last_trk) begin
      r.count_error = 1'b1;
    end else begin
      done = 1'b0;
      for (int z = 0; z < ZONE_COUNT && !done; z++) begin
        w = zone_at(z);
        if (w.first == 0) begin
          done = 1'b1;
        end else if (w.last == 0 || tr <= w.last) begin
          r.track_sectors = w.secs;
          done = 1'b1;
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    errors++;
  endtask

  // Feeds queued queries; a new item goes out only once the current beat is taken.
  always @(posedge clk) begin : driver
    if (rst_n) begin
      if (start && !busy) begin
        expected_maps.push_back(map_query(in_item));
        accepted_cnt++;
      end
      if (!start || !busy) begin
        if (query_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start   <= 1'b1;
          in_item <= query_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    out_t want;
    if (rst_n && out_strobe) begin
      if (expected_maps.size() == 0) begin
        report_mismatch("result beat with no query waiting");
      end else begin
        want = expected_maps.pop_front();
        if (out_item.block_index !== want.block_index)
          report_mismatch($sformatf("block_index %0d, expected %0d",
                                    out_item.block_index, want.block_index));
        if (out_item.byte_offset !== want.byte_offset)
          report_mismatch($sformatf("byte_offset %0d, expected %0d",
                                    out_item.byte_offset, want.byte_offset));
        if (out_item.map_error !== want.map_error)
          report_mismatch($sformatf("map_error %0d, expected %0d",
                                    out_item.map_error, want.map_error));
        if (out_item.track_sectors !== want.track_sectors)
          report_mismatch($sformatf("track_sectors %0d, expected %0d",
                                    out_item.track_sectors, want.track_sectors));
        if (out_item.count_error !== want.count_error)
          report_mismatch($sformatf("count_error %0d, expected %0d",
                                    out_item.count_error, want.count_error));
      end
    end
  end

  // Counts cycles without any beat while work is still outstanding.
  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_strobe || (cfg_valid && cfg_ready) ||
        (accepted_cnt == queued_cnt && expected_maps.size() == 0 && !cfg_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("zoned_track_sector_to_block_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic add_query(input logic [7:0] track, input logic [7:0] sector);
    query_q.push_back('{track_in: track, sector_in: sector});
    queued_cnt++;
  endtask

  // Mostly legal queries against the current table, with boundary and noise items.
  task automatic add_random_query();
    int          pick;
    int          cand [$];
    int unsigned lim [ZONE_COUNT];
    int unsigned minsec;
    int          z;
    zone_t       w;
    logic [7:0]  sector;
    pick = $urandom_range(0, 99);
    minsec = 256;
    for (int i = 0; i < ZONE_COUNT; i++) begin
      w = zone_at(i);
      if (w.first == 0) break;
      if (w.secs < minsec) minsec = w.secs;
      if (minsec == 0) break;
      lim[i] = minsec;
      if (w.last >= w.first) cand.push_back(i);
    end
    if (pick < 20 || (pick >= 26 && cand.size() == 0)) begin
      add_query(8'($urandom), 8'($urandom));
    end else if (pick < 26) begin
      case ($urandom_range(0, 2))
        0:       add_query(8'd0, 8'($urandom_range(0, 3)));
        1:       add_query(last_trk, 8'($urandom_range(0, 3)));
        default: add_query(last_trk + 8'd1, 8'($urandom_range(0, 3)));
      endcase
    end else begin
      z = cand[$urandom_range(0, cand.size() - 1)];
      w = zone_at(z);
      case ($urandom_range(0, 9))
        0:       sector = 8'(lim[z]);
        1:       sector = 8'(lim[z] - 1);
        default: sector = 8'($urandom_range(0, lim[z] - 1));
      endcase
      add_query(8'($urandom_range(w.first, w.last)), sector);
    end
  endtask

  // Assumes it is entered right after a rising edge.
  task automatic cfg_write(input cfg_idx_t idx, input logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx <= CFG_ZONE_3) zone_reg[idx[1:0]] = data;
    else if (idx == CFG_LAST_TRACK) last_trk = data[7:0];
  endtask

  task automatic settle();
    while (accepted_cnt != queued_cnt || expected_maps.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic load_table(input int phase);
    zone_t      w [ZONE_REGS];
    logic [7:0] lt;
    int         cur;
    int         z;
    logic [7:0] tmp;
    cur = $urandom_range(1, 4);
    for (int i = 0; i < ZONE_REGS; i++) begin
      w[i].first = 8'(cur);
      w[i].last  = 8'(cur + $urandom_range(0, 60));
      w[i].secs  = 8'($urandom_range(1, 255));
      cur = w[i].last + 1;
    end
    lt = 8'($urandom);
    case (phase)
      1: lt = 8'd255;
      2: begin
        for (int i = 0; i < ZONE_REGS; i++) w[i] = 24'hFFFFFF;
        lt = 8'd255;
      end
      3: begin
        z = $urandom_range(1, ZONE_REGS - 1);
        w[z].first = 8'd0;
      end
      4: begin
        for (int i = 0; i < ZONE_REGS; i++) w[i] = '0;
        lt = 8'd0;
      end
      5: begin
        // One empty zone and one zone whose bounds run backwards.
        z = $urandom_range(0, ZONE_REGS - 1);
        w[z].secs = 8'd0;
        z = $urandom_range(0, ZONE_REGS - 1);
        tmp = w[z].first;
        w[z].first = w[z].last + 8'd1;
        w[z].last = tmp;
      end
      6: begin
        for (int i = 0; i < ZONE_REGS; i++) w[i] = 24'($urandom);
      end
      default: begin
        w[2].last = 8'd0;
        lt = w[ZONE_REGS-1].last;
      end
    endcase
    cfg_write(CFG_ZONE_0, w[0]);
    cfg_write(CFG_ZONE_1, w[1]);
    cfg_write(CFG_ZONE_2, w[2]);
    cfg_write(CFG_ZONE_3, w[3]);
    cfg_write(CFG_LAST_TRACK, {16'($urandom), lt});
    // Indexes past the last register must leave the table alone.
    cfg_write(cfg_idx_t'(CFG_LAST_TRACK + $urandom_range(1, 3)), 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    zone_reg[0] = ZONE_0_RESET;
    zone_reg[1] = ZONE_1_RESET;
    zone_reg[2] = ZONE_2_RESET;
    zone_reg[3] = ZONE_3_RESET;
    last_trk    = LAST_TRACK_RESET;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed queries against the table the block comes out of reset with.
    add_query(8'd0, 8'd0);
    add_query(8'd0, 8'd255);
    add_query(8'd1, 8'd0);
    add_query(8'd1, 8'd20);
    add_query(8'd1, 8'd21);
    add_query(8'd17, 8'd20);
    add_query(8'd18, 8'd0);
    add_query(8'd18, 8'd18);
    add_query(8'd18, 8'd19);
    add_query(8'd24, 8'd18);
    add_query(8'd25, 8'd0);
    add_query(8'd30, 8'd17);
    add_query(8'd31, 8'd0);
    add_query(8'd31, 8'd16);
    add_query(8'd31, 8'd20);
    add_query(8'd35, 8'd16);
    add_query(8'd35, 8'd17);
    add_query(8'd36, 8'd0);
    add_query(8'd128, 8'd127);
    add_query(8'd255, 8'd0);
    add_query(8'd255, 8'd255);

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        settle();
        load_table(phase);
      end
      case (phase % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 51;
        default: idle_pct = 27;
      endcase
      repeat (PER_PHASE) add_random_query();
    end

    settle();
    if (errors == 0) begin
      $display("zoned_track_sector_to_block_tb: clean");
    end else begin
      $display("zoned_track_sector_to_block_tb: errors");
    end
    $finish;
  end

endmodule
